/* rtl/cfr_pkg.sv */
// cfr_pkg: shared types and constants of the command frame receiver.
// Holds the frame sync bytes, the result kind codes and the release request
// passed from the parser to the release sequencer. Depends on nothing.
package cfr_pkg;

  // Frame header bytes
  localparam logic [7:0] SYNC_DOLLAR = 8'h24;
  localparam logic [7:0] SYNC_M      = 8'h4D;
  localparam logic [7:0] SYNC_LT     = 8'h3C;

  // Width of the length field in a release request (covers any length an 8-bit size byte gives)
  localparam int unsigned REQ_LEN_W = 8;

  // Result kind; also selects the release action in a request
  typedef enum logic [1:0] {
    KIND_OTHER   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2
  } cfr_kind_t;

  // Release request from parser to release sequencer
  typedef struct packed {
    logic                 start;
    cfr_kind_t            kind;
    logic [7:0]           command;
    logic [7:0]           data;
    logic [REQ_LEN_W-1:0] length;
  } cfr_req_t;

endpackage

/* rtl/cfr_if.sv */
// cfr_if: valid/ready channel interfaces of the command frame receiver.
// cfr_in_if moves one received byte per word, cfr_out_if one result word.
// Depends on nothing.
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] command;
  logic [7:0] data;
  logic [5:0] byte_index;
  logic [6:0] frame_size;
  logic       last;

  modport source (output valid, output kind, output command, output data,
                  output byte_index, output frame_size, output last, input ready);
  modport sink   (input valid, input kind, input command, input data,
                  input byte_index, input frame_size, input last, output ready);
endinterface

/* rtl/cfr_payload_mem.sv */
// cfr_payload_mem: payload byte store, one write port and one read port.
// Read data is registered; contents are not reset.
// Depends on nothing.
module cfr_payload_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write payload bytes as they arrive
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/cfr_parser.sv */
// cfr_parser: header match, size check, checksum and payload fill.
// Writes payload bytes into cfr_payload_mem and raises release requests.
// Depends on cfr_pkg.
module cfr_parser import cfr_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned AW           = 6,
  parameter int unsigned LEN_W        = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output cfr_req_t      req
);

  typedef enum logic [2:0] {
    P_IDLE,
    P_DOLLAR,
    P_M,
    P_ARROW,
    P_SIZE,
    P_BODY
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [7:0]       csum_r, csum_nxt;
  logic [7:0]       cmd_r, cmd_nxt;

  // Decode the accepted word against the current parse position
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    csum_nxt  = csum_r;
    cmd_nxt   = cmd_r;
    wr_en     = 1'b0;
    wr_addr   = fill_r[AW-1:0];
    wr_data   = rx_byte;
    req       = '0;
    if (accept) begin
      case (state_r)
        P_IDLE: begin
          if (rx_byte == SYNC_DOLLAR) begin
            state_nxt = P_DOLLAR;
          end else begin
            req.start = 1'b1;
            req.kind  = KIND_OTHER;
            req.data  = rx_byte;
          end
        end
        P_DOLLAR: state_nxt = (rx_byte == SYNC_M) ? P_M : P_IDLE;
        P_M:      state_nxt = (rx_byte == SYNC_LT) ? P_ARROW : P_IDLE;
        P_ARROW: begin
          // Drop an oversized frame
          if (rx_byte > 8'(BUFFER_DEPTH)) begin
            state_nxt = P_IDLE;
          end else begin
            len_nxt   = LEN_W'(rx_byte);
            fill_nxt  = '0;
            csum_nxt  = rx_byte;
            state_nxt = P_SIZE;
          end
        end
        P_SIZE: begin
          cmd_nxt   = rx_byte;
          csum_nxt  = csum_r ^ rx_byte;
          state_nxt = P_BODY;
        end
        P_BODY: begin
          if (fill_r < len_r) begin
            // Store payload byte and fold it into the checksum
            csum_nxt = csum_r ^ rx_byte;
            wr_en    = 1'b1;
            fill_nxt = fill_r + LEN_W'(1);
          end else begin
            // Checksum word: release on match, drop otherwise
            state_nxt = P_IDLE;
            if (csum_r == rx_byte) begin
              req.start   = 1'b1;
              req.kind    = (len_r == '0) ? KIND_EMPTY : KIND_PAYLOAD;
              req.command = cmd_r;
              req.length  = REQ_LEN_W'(len_r);
            end
          end
        end
        default: state_nxt = P_IDLE;
      endcase
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      len_r   <= '0;
      fill_r  <= '0;
      csum_r  <= '0;
      cmd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      csum_r  <= csum_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  // A frame in progress never exceeds the buffer
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == P_SIZE || state_r == P_BODY) |-> len_r <= LEN_W'(BUFFER_DEPTH))
    else $error("frame length above buffer depth");

  // The fill position never runs past the frame length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == P_BODY |-> fill_r <= len_r)
    else $error("fill offset past frame length");

  // A payload release only follows a non-empty frame whose payload was fully stored
  a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && req.kind == KIND_PAYLOAD) |-> (len_r != '0 && fill_r == len_r))
    else $error("payload release without stored payload");

endmodule

/* rtl/cfr_release.sv */
// cfr_release: release sequencer and output register.
// Reads stored payload bytes one per result and drives the result channel.
// Depends on cfr_pkg.
module cfr_release import cfr_pkg::*; #(
  parameter int unsigned AW    = 6,
  parameter int unsigned LEN_W = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfr_req_t      req,
  output logic          busy,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_command,
  output logic [7:0]    out_data,
  output logic [5:0]    out_byte_index,
  output logic [6:0]    out_frame_size,
  output logic          out_last
);

  typedef enum logic [1:0] {
    R_IDLE,
    R_LOAD,
    R_SEND
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  cfr_kind_t        kind_r, kind_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [5:0]       bidx_r, bidx_nxt;
  logic [6:0]       size_r, size_nxt;
  logic             last_r, last_nxt;
  logic [7:0]       idx_ext;
  logic [7:0]       len_ext;

  assign idx_ext = 8'(idx_r);
  assign len_ext = 8'(len_r);

  // Sequence requests and memory reads
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    kind_nxt  = kind_r;
    data_nxt  = data_r;
    bidx_nxt  = bidx_r;
    size_nxt  = size_r;
    last_nxt  = last_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    case (state_r)
      R_IDLE: begin
        if (req.start) begin
          case (req.kind)
            KIND_OTHER: begin
              kind_nxt  = KIND_OTHER;
              cmd_nxt   = '0;
              data_nxt  = req.data;
              bidx_nxt  = '0;
              size_nxt  = '0;
              last_nxt  = 1'b1;
              state_nxt = R_SEND;
            end
            KIND_EMPTY: begin
              kind_nxt  = KIND_EMPTY;
              cmd_nxt   = req.command;
              data_nxt  = '0;
              bidx_nxt  = '0;
              size_nxt  = '0;
              last_nxt  = 1'b1;
              state_nxt = R_SEND;
            end
            KIND_PAYLOAD: begin
              // Fetch first payload byte
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = '0;
              len_nxt   = LEN_W'(req.length);
              cmd_nxt   = req.command;
              state_nxt = R_LOAD;
            end
            default: state_nxt = R_IDLE;
          endcase
        end
      end
      R_LOAD: begin
        // Capture read data into the output register
        kind_nxt  = KIND_PAYLOAD;
        data_nxt  = rd_data;
        bidx_nxt  = idx_ext[5:0];
        size_nxt  = len_ext[6:0];
        last_nxt  = (LEN_W'(idx_r) + LEN_W'(1)) == len_r;
        state_nxt = R_SEND;
      end
      R_SEND: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = R_IDLE;
          end else begin
            // Fetch next payload byte as this word leaves
            idx_nxt   = idx_r + AW'(1);
            rd_en     = 1'b1;
            rd_addr   = idx_r + AW'(1);
            state_nxt = R_LOAD;
          end
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  // Hold state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      idx_r   <= '0;
      len_r   <= '0;
      cmd_r   <= '0;
      kind_r  <= KIND_OTHER;
      data_r  <= '0;
      bidx_r  <= '0;
      size_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      kind_r  <= kind_nxt;
      data_r  <= data_nxt;
      bidx_r  <= bidx_nxt;
      size_r  <= size_nxt;
      last_r  <= last_nxt;
    end
  end

  assign busy           = state_r != R_IDLE;
  assign out_valid      = state_r == R_SEND;
  assign out_kind       = kind_r;
  assign out_command    = cmd_r;
  assign out_data       = data_r;
  assign out_byte_index = bidx_r;
  assign out_frame_size = size_r;
  assign out_last       = last_r;

  // Requests only arrive while the sequencer is free
  a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == R_IDLE)
    else $error("release request while busy");

  // Loading always follows a memory read
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == R_LOAD |-> $past(rd_en))
    else $error("load without preceding read");

  // Payload reads stay inside the released frame
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == R_LOAD |-> LEN_W'(idx_r) < len_r)
    else $error("payload index past frame length");

endmodule

/* rtl/command_frame_receiver.sv */
// An idle byte passed through is shown in the cycle after its word is accepted. A good
// frame's first result goes through a memory read (R_LOAD) unless the frame is empty;
// each payload byte takes one read and one output load while the sink is ready.
// Throughput: one input word per cycle for words giving no result; a word giving a
// result holds input off until the cycle after its last result is taken. Reset (rst_n,
// synchronous) returns the parser to idle and empties the output; memory is not cleared.
module command_frame_receiver import cfr_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  cfr_in_if.sink     in_ch,
  cfr_out_if.source  out_ch
);

  localparam int unsigned AW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned LEN_W = $clog2(BUFFER_DEPTH + 1);

  logic          accept;
  logic          busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  cfr_req_t      req;

  // Take a word only while no release is pending
  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;

  cfr_parser #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW),
    .LEN_W        (LEN_W)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .req     (req)
  );

  cfr_payload_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cfr_release #(
    .AW    (AW),
    .LEN_W (LEN_W)
  ) u_release (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .busy           (busy),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_command    (out_ch.command),
    .out_data       (out_ch.data),
    .out_byte_index (out_ch.byte_index),
    .out_frame_size (out_ch.frame_size),
    .out_last       (out_ch.last)
  );

endmodule
